// File: sv/clock_page_replacement_mmu_unit_macros.svh
// Assertion macros used by the checker file cpr_checker.sv.
`ifndef CLOCK_PAGE_REPLACEMENT_MMU_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MMU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/cpr_pkg.sv
package cpr_pkg;

	localparam int VA_W = 30;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 120;
	localparam int OB_W = 5;
	localparam int FC_W = 9;
	localparam int CNT_W = 32;
	localparam int PHYS_W = 24;
	localparam int FRAME_OUT_W = 8;
	localparam int PAGE_OUT_W = 14;
	localparam int PADDR_W = 3;
	localparam int OB_MAX = 16;
	localparam int OB_RESET = 12;
	localparam int FC_RESET = 256;

	localparam logic [PADDR_W-1:0] ADDR_OFFSET_BITS = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_FRAME_COUNT = 3'd4;

	// flag store bit positions
	localparam int FLAG_VALID = 0;
	localparam int FLAG_REF = 1;

	typedef struct packed {
		logic cap;
		logic hit_upd;
		logic fill;
		logic sweep_start;
		logic sw_rd_flag;
		logic sw_clear_ref;
		logic sw_evict;
		logic install;
		logic clr_step;
		logic out_load;
	} cpr_cmd_t;

	typedef struct packed {
		logic oor;
		logic pg_valid;
		logic pg_ref;
		logic room;
		logic clr_last;
		logic out_busy;
	} cpr_sts_t;

endpackage

// File: sv/cpr_ram.sv
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/cpr_ctrl.sv
module cpr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  cpr_pkg::cpr_sts_t   sts,
	output cpr_pkg::cpr_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_CHECK,
		ST_SW_RD,
		ST_SW_OWN,
		ST_SW_CHK,
		ST_INSTALL,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: cmd.cap = s_tvalid;
			ST_CHECK: begin
				if (!sts.oor) begin
					if (sts.pg_valid) cmd.hit_upd = 1'b1;
					else if (sts.room) cmd.fill = 1'b1;
					else cmd.sweep_start = 1'b1;
				end
			end
			ST_SW_OWN: cmd.sw_rd_flag = 1'b1;
			ST_SW_CHK: begin
				if (sts.pg_ref) cmd.sw_clear_ref = 1'b1;
				else cmd.sw_evict = 1'b1;
			end
			ST_INSTALL: cmd.install = 1'b1;
			ST_FINISH: cmd.out_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE: if (s_tvalid) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.oor || sts.pg_valid || sts.room) state_q <= ST_FINISH;
					else state_q <= ST_SW_RD;
				end
				ST_SW_RD: state_q <= ST_SW_OWN;
				ST_SW_OWN: state_q <= ST_SW_CHK;
				ST_SW_CHK: begin
					if (sts.pg_ref) state_q <= ST_SW_RD;
					else state_q <= ST_INSTALL;
				end
				ST_INSTALL: state_q <= ST_FINISH;
				ST_FINISH: if (!sts.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

// File: sv/cpr_dp.sv
module cpr_dp #(
	parameter int VIRTUAL_PAGES = 16384,
	parameter int MAX_FRAMES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpr_pkg::cpr_cmd_t              cmd,
	output cpr_pkg::cpr_sts_t              sts,
	input  logic [cpr_pkg::VA_W-1:0]       va,
	input  logic [cpr_pkg::OB_W-1:0]       ob_cfg,
	input  logic [cpr_pkg::FC_W-1:0]       fc_cfg,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [cpr_pkg::M_DATA_W-1:0]   m_tdata
);

	localparam int PW = $clog2(VIRTUAL_PAGES);
	localparam int FW = $clog2(MAX_FRAMES);
	localparam int CW = FW + 1;

	// used frame count, clamped to 1..MAX_FRAMES
	logic [CW-1:0] fc;
	always_comb begin
		if (fc_cfg == '0) fc = CW'(1);
		else if (32'(fc_cfg) > 32'(MAX_FRAMES)) fc = CW'(MAX_FRAMES);
		else fc = CW'(fc_cfg);
	end

	logic [cpr_pkg::OB_W-1:0] ob;
	assign ob = (32'(ob_cfg) > 32'(cpr_pkg::OB_MAX)) ? cpr_pkg::OB_W'(cpr_pkg::OB_MAX) : ob_cfg;

	logic [cpr_pkg::VA_W-1:0] page_full;
	assign page_full = va >> ob;

	logic [cpr_pkg::OB_W-1:0] ob_q;
	logic [cpr_pkg::VA_W-1:0] offset_q;
	logic [PW-1:0] page_q;
	logic oor_q;
	logic [FW-1:0] frame_q;
	logic [FW-1:0] hand_q;
	logic [CW-1:0] filled_q;
	logic [PW-1:0] owner_q;
	logic [PW-1:0] victim_q;
	logic hit_q, evict_q;
	logic [cpr_pkg::CNT_W-1:0] refs_q, faults_q;
	logic [PW-1:0] clr_q;

	// RAM ports
	logic          flg_we;
	logic [PW-1:0] flg_waddr, flg_raddr;
	logic [1:0]    flg_wdata, flg_rdata;
	logic          pf_we;
	logic [FW-1:0] pf_rdata;
	logic          own_we;
	logic [FW-1:0] own_waddr;
	logic [PW-1:0] own_rdata;

	logic [CW-1:0] hand_inc;
	assign hand_inc = CW'(hand_q) + CW'(1);

	always_comb begin
		flg_we = 1'b0;
		flg_waddr = page_q;
		flg_wdata = 2'b11;
		if (cmd.clr_step) begin
			flg_we = 1'b1;
			flg_waddr = clr_q;
			flg_wdata = 2'b00;
		end else if (cmd.hit_upd || cmd.fill || cmd.install) begin
			flg_we = 1'b1;
		end else if (cmd.sw_clear_ref) begin
			flg_we = 1'b1;
			flg_waddr = owner_q;
			flg_wdata = {1'b0, flg_rdata[cpr_pkg::FLAG_VALID]};
		end else if (cmd.sw_evict) begin
			flg_we = 1'b1;
			flg_waddr = owner_q;
			flg_wdata = 2'b00;
		end
	end

	assign flg_raddr = cmd.sw_rd_flag ? own_rdata : page_q;
	assign pf_we = cmd.fill || cmd.install;
	assign own_we = cmd.fill || cmd.install;
	assign own_waddr = cmd.fill ? filled_q[FW-1:0] : frame_q;

	cpr_ram #(.WIDTH(2), .DEPTH(VIRTUAL_PAGES)) u_flags (
		.clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
		.raddr(flg_raddr), .rdata(flg_rdata)
	);

	cpr_ram #(.WIDTH(FW), .DEPTH(VIRTUAL_PAGES)) u_pframe (
		.clk(clk), .we(pf_we), .waddr(page_q), .wdata(own_waddr),
		.raddr(page_q), .rdata(pf_rdata)
	);

	cpr_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_owner (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(page_q),
		.raddr(hand_q), .rdata(own_rdata)
	);

	assign sts.oor = oor_q;
	assign sts.pg_valid = flg_rdata[cpr_pkg::FLAG_VALID];
	assign sts.pg_ref = flg_rdata[cpr_pkg::FLAG_REF];
	assign sts.room = filled_q < fc;
	assign sts.clr_last = (clr_q == PW'(VIRTUAL_PAGES - 1));
	assign sts.out_busy = m_tvalid && !m_tready;

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ob_q <= ob;
			offset_q <= va & ((cpr_pkg::VA_W'(1) << ob) - cpr_pkg::VA_W'(1));
			page_q <= page_full[PW-1:0];
			oor_q <= 32'(page_full) >= 32'(VIRTUAL_PAGES);
			frame_q <= '0;
			hit_q <= 1'b0;
			evict_q <= 1'b0;
			victim_q <= '0;
		end
		if (cmd.hit_upd) begin
			frame_q <= pf_rdata;
			hit_q <= 1'b1;
		end
		if (cmd.fill) frame_q <= filled_q[FW-1:0];
		if (cmd.sw_rd_flag) owner_q <= own_rdata;
		if (cmd.sw_evict) begin
			frame_q <= hand_q;
			evict_q <= 1'b1;
			victim_q <= owner_q;
		end
	end

	// policy and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q <= '0;
			filled_q <= '0;
			refs_q <= '0;
			faults_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + PW'(1);
			if (cmd.cap && refs_q != '1) refs_q <= refs_q + cpr_pkg::CNT_W'(1);
			if ((cmd.fill || cmd.sweep_start) && faults_q != '1)
				faults_q <= faults_q + cpr_pkg::CNT_W'(1);
			if (cmd.fill) filled_q <= filled_q + CW'(1);
			// wrap the hand if the frame count dropped to or below it
			if (cmd.sweep_start && CW'(hand_q) >= fc) hand_q <= '0;
			if (cmd.sw_clear_ref) hand_q <= (hand_inc == fc) ? '0 : hand_inc[FW-1:0];
		end
	end

	// result register
	logic [31:0] phys_w;
	assign phys_w = oor_q ? 32'd0 : ((32'(frame_q) << ob_q) | 32'(offset_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {7'd0, faults_q, refs_q, oor_q,
				cpr_pkg::PAGE_OUT_W'(32'(victim_q)), evict_q, hit_q,
				cpr_pkg::FRAME_OUT_W'(32'(frame_q)), phys_w[cpr_pkg::PHYS_W-1:0]};
		end
	end

endmodule

// File: sv/clock_page_replacement_mmu_unit.sv
// Clock (second-chance) page-replacement MMU.
// Input stream (s_*): one beat per virtual address, 30 bits in s_tdata.
// Output stream (m_*): one result beat per input beat, in order.
// Config (APB): offset_bits at 0x0, frame_count at 0x4; write only while idle.
// Steps: a hit, an out-of-range page or a fill of a fresh frame goes from accept
// through the look and check steps to the finish step, which loads the result
// register; the next beat is accepted once the controller is back in idle. A
// sweep fault adds an owner read, a flag read and a flag update per frame visited
// and an install step; it visits at most the clamped frame_count + 1 frames. One item is in work at a time.
// Reset: clears all VIRTUAL_PAGES entries of the flag store, with
// s_tready low meanwhile; config returns to offset_bits 12, frame_count 256.
// Stall: a result waits in the output register; the next beat is still
// accepted and worked, and it stops only at its finish step until m_tready.
module clock_page_replacement_mmu_unit #(
	parameter int VIRTUAL_PAGES = 16384,
	parameter int MAX_FRAMES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [29:0] virtual_address
	input  logic [cpr_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [23:0] physical_address, [31:24] frame_number, [32] hit, [33] evicted,
	// [47:34] evicted_page, [48] page_out_of_range, [80:49] reference_count,
	// [112:81] fault_count
	output logic [cpr_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpr_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	cpr_pkg::cpr_cmd_t cmd;
	cpr_pkg::cpr_sts_t sts;

	logic [cpr_pkg::OB_W-1:0] offset_bits_q;
	logic [cpr_pkg::FC_W-1:0] frame_count_q;

	assign pready = 1'b1;

	// register writes complete on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= cpr_pkg::OB_W'(cpr_pkg::OB_RESET);
			frame_count_q <= cpr_pkg::FC_W'(cpr_pkg::FC_RESET);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr)
				cpr_pkg::ADDR_OFFSET_BITS: offset_bits_q <= pwdata[cpr_pkg::OB_W-1:0];
				cpr_pkg::ADDR_FRAME_COUNT: frame_count_q <= pwdata[cpr_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			cpr_pkg::ADDR_OFFSET_BITS: prdata = 32'(offset_bits_q);
			cpr_pkg::ADDR_FRAME_COUNT: prdata = 32'(frame_count_q);
			default: prdata = 32'd0;
		endcase
	end

	cpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	cpr_dp #(.VIRTUAL_PAGES(VIRTUAL_PAGES), .MAX_FRAMES(MAX_FRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.va(s_tdata[cpr_pkg::VA_W-1:0]), .ob_cfg(offset_bits_q), .fc_cfg(frame_count_q),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata)
	);

endmodule

// File: sv/cpr_checker.sv
`include "clock_page_replacement_mmu_unit_macros.svh"

module cpr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cpr_pkg::M_DATA_W-1:0]  m_tdata
);

	// a stalled result holds
	`CPR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// one item in work at a time
	`CPR_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a hit never evicts
	`CPR_ASSERT_IMPL(a_hit_no_evict, clk, arst_n, m_tvalid && m_tdata[32], !m_tdata[33])
	// an out-of-range page gives an empty result
	`CPR_ASSERT_IMPL(a_oor_empty, clk, arst_n, m_tvalid && m_tdata[48], m_tdata[47:0] == '0)

endmodule

bind clock_page_replacement_mmu_unit cpr_checker u_cpr_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
